/* rtl/gld_pkg.sv */
// Shared types, codes and helpers for the GIF LZW decoder.
`default_nettype none
package gld_pkg;

  // Reset value of the minimum code size register.
  localparam logic [3:0] MCS_RESET = 4'd8;
  localparam logic [3:0] MCS_LOW   = 4'd2;
  localparam logic [3:0] MCS_HIGH  = 4'd8;

  // Operation codes of an input request.
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_PIXEL     = 3'd0,
    ST_BYTE_OK   = 3'd1,
    ST_NEED_DATA = 3'd2,
    ST_END       = 3'd3,
    ST_DROPPED   = 3'd4
  } gld_status_e;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_REQ,
    BK_LOAD,
    BK_POP,
    BK_WALK,
    BK_WAIT,
    BK_FIX
  } gld_state_e;

  // One queued request.
  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } gld_item_t;

  // Configuration write toward the back end.
  typedef struct packed {
    logic       restart;
    logic [3:0] min_code_size;
  } gld_cfg_t;

  // Clamp the minimum code size to its legal range.
  function automatic logic [3:0] eff_min(input logic [3:0] mcs);
    logic [3:0] r;
    if (mcs < MCS_LOW) begin
      r = MCS_LOW;
    end else if (mcs > MCS_HIGH) begin
      r = MCS_HIGH;
    end else begin
      r = mcs;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/gld_ram.sv */
// Generic single write port RAM with a registered read port.
`default_nettype none
module gld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

/* rtl/gld_front.sv */
// Front end: accepts requests and holds them in a two-entry queue.
`default_nettype none
module gld_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               op_i,
  input  logic [7:0]         data_byte_i,
  output logic               item_valid_o,
  output gld_pkg::gld_item_t item_o,
  input  logic               item_pop_i
);
  import gld_pkg::*;

  gld_item_t  ent_q [2];
  gld_item_t  ent_d [2];
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  logic [1:0] after_pop;

  assign in_stall_o   = (cnt_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = ent_q[0];

  // Shift on pop, then append the new request behind what remains.
  always_comb begin
    ent_d[0]  = ent_q[0];
    ent_d[1]  = ent_q[1];
    after_pop = cnt_q;
    if (item_pop_i && item_valid_o) begin
      ent_d[0]  = ent_q[1];
      after_pop = cnt_q - 2'd1;
    end
    if (push) begin
      ent_d[after_pop[0]] = '{op: op_i, data: data_byte_i};
    end
    cnt_d = after_pop + {1'b0, push};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q[0] <= ent_d[0];
    ent_q[1] <= ent_d[1];
  end

endmodule
`default_nettype wire

/* rtl/gld_back.sv */
// Back end: byte FIFO, code unpacking, dictionary walk and pixel stack.
`default_nettype none
module gld_back #(
  parameter int DICT_DEPTH    = 4096,
  parameter int MAX_CODE_BITS = 12,
  parameter int FIFO_DEPTH    = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gld_pkg::gld_cfg_t  cfg_i,
  input  logic               item_valid_i,
  input  gld_pkg::gld_item_t item_i,
  output logic               item_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         pixel_index_o,
  output logic [2:0]         status_o
);
  import gld_pkg::*;

  localparam int AW    = $clog2(DICT_DEPTH);
  localparam int NE_W  = $clog2(DICT_DEPTH + 1);
  localparam int CW    = MAX_CODE_BITS;
  localparam int CMP_W = (NE_W > CW) ? NE_W : CW;
  localparam int FA_W  = $clog2(FIFO_DEPTH);
  localparam int FC_W  = $clog2(FIFO_DEPTH + 1);

  gld_state_e     state_q, state_d;
  logic [NE_W-1:0] stk_cnt_q, stk_cnt_d;
  logic [FC_W-1:0] fcnt_q, fcnt_d;
  logic [FA_W-1:0] rd_q, rd_d, wr_q, wr_d;
  logic [23:0]     buf_q, buf_d;
  logic [4:0]      bcnt_q, bcnt_d;
  logic [3:0]      cw_q, cw_d;
  logic [NE_W-1:0] ne_q, ne_d;
  logic [CW-1:0]   prev_q, prev_d;
  logic            have_q, have_d;
  logic            done_q, done_d;
  logic [CW-1:0]   n_q, n_d;
  logic [CW-1:0]   code_q, code_d;
  logic            kw_q, kw_d;
  logic [7:0]      first_q, first_d;
  logic            ov_q, ov_d;
  logic [7:0]      opix_q, opix_d;
  gld_status_e     ost_q, ost_d;

  // Memory port signals.
  logic            fifo_we;
  logic [7:0]      fifo_rdata;
  logic            stk_we;
  logic [AW-1:0]   stk_waddr;
  logic [7:0]      stk_wdata, stk_rdata;
  logic            dict_we;
  logic [CW+7:0]   dict_rdata;

  // Decode helpers.
  logic [3:0]      emin;
  logic [CMP_W-1:0] clear_c, stop_c, code_c, n_c, ne_c;
  logic [23:0]     masked;
  logic [CW-1:0]   code;
  logic [NE_W-1:0] ne_inc;
  logic            out_free, emit, kw;
  gld_status_e     emit_st;
  logic [7:0]      emit_pix;
  logic [AW-1:0]   stk_raddr;

  assign emin     = eff_min(cfg_i.restart ? cfg_i.min_code_size : cfg_i.min_code_size);
  assign clear_c  = CMP_W'(1) << emin;
  assign stop_c   = clear_c + CMP_W'(1);
  assign masked   = buf_q & ((24'(1) << cw_q) - 24'(1));
  assign code     = masked[CW-1:0];
  assign code_c   = CMP_W'(code);
  assign n_c      = CMP_W'(n_q);
  assign ne_c     = CMP_W'(ne_q);
  assign ne_inc   = ne_q + NE_W'(1);
  assign out_free = !ov_q || !out_stall_i;
  assign kw       = (code_c == ne_c);
  assign stk_raddr = AW'(stk_cnt_q - NE_W'(1));

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_d   = state_q;
    stk_cnt_d = stk_cnt_q;
    fcnt_d    = fcnt_q;
    rd_d      = rd_q;
    wr_d      = wr_q;
    buf_d     = buf_q;
    bcnt_d    = bcnt_q;
    cw_d      = cw_q;
    ne_d      = ne_q;
    prev_d    = prev_q;
    have_d    = have_q;
    done_d    = done_q;
    n_d       = n_q;
    code_d    = code_q;
    kw_d      = kw_q;
    first_d   = first_q;
    item_pop_o = 1'b0;
    fifo_we   = 1'b0;
    stk_we    = 1'b0;
    stk_waddr = stk_cnt_q[AW-1:0];
    stk_wdata = 8'd0;
    dict_we   = 1'b0;
    emit      = 1'b0;
    emit_st   = ST_PIXEL;
    emit_pix  = 8'd0;

    unique case (state_q)
      BK_IDLE: begin
        if (item_valid_i && out_free) begin
          item_pop_o = 1'b1;
          if (item_i.op == OP_PUSH) begin
            emit = 1'b1;
            if (fcnt_q < FC_W'(FIFO_DEPTH)) begin
              fifo_we = 1'b1;
              wr_d    = (wr_q == FA_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + FA_W'(1);
              fcnt_d  = fcnt_q + FC_W'(1);
              emit_st = ST_BYTE_OK;
            end else begin
              emit_st = ST_DROPPED;
            end
          end else begin
            state_d = BK_REQ;
          end
        end
      end
      BK_REQ: begin
        priority if (stk_cnt_q != '0) begin
          stk_cnt_d = stk_cnt_q - NE_W'(1);
          state_d   = BK_POP;
        end else if (done_q) begin
          emit    = 1'b1;
          emit_st = ST_END;
          state_d = BK_IDLE;
        end else if (bcnt_q < {1'b0, cw_q}) begin
          if (fcnt_q != '0) begin
            rd_d    = (rd_q == FA_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + FA_W'(1);
            fcnt_d  = fcnt_q - FC_W'(1);
            state_d = BK_LOAD;
          end else begin
            emit    = 1'b1;
            emit_st = ST_NEED_DATA;
            state_d = BK_IDLE;
          end
        end else begin
          // A whole code is buffered: take it and classify it.
          buf_d  = buf_q >> cw_q;
          bcnt_d = bcnt_q - {1'b0, cw_q};
          priority if (code_c == clear_c) begin
            cw_d   = emin + 4'd1;
            ne_d   = NE_W'(clear_c + CMP_W'(2));
            have_d = 1'b0;
          end else if (code_c == stop_c) begin
            done_d = 1'b1;
          end else if (!have_q) begin
            if (code_c > stop_c) begin
              done_d = 1'b1;
            end else begin
              stk_we    = 1'b1;
              stk_wdata = code[7:0];
              stk_cnt_d = stk_cnt_q + NE_W'(1);
              prev_d    = code;
              have_d    = 1'b1;
            end
          end else if (code_c > ne_c) begin
            done_d = 1'b1;
          end else begin
            // The next free code repeats the previous string; its slot is patched later.
            if (kw) begin
              stk_we    = 1'b1;
              stk_cnt_d = stk_cnt_q + NE_W'(1);
            end
            n_d     = kw ? prev_q : code;
            code_d  = code;
            kw_d    = kw;
            state_d = BK_WALK;
          end
        end
      end
      BK_LOAD: begin
        buf_d   = buf_q | (24'(fifo_rdata) << bcnt_q);
        bcnt_d  = bcnt_q + 5'd8;
        state_d = BK_REQ;
      end
      BK_POP: begin
        emit     = 1'b1;
        emit_st  = ST_PIXEL;
        emit_pix = stk_rdata;
        state_d  = BK_IDLE;
      end
      BK_WALK: begin
        if (n_c > stop_c && n_c < CMP_W'(DICT_DEPTH) &&
            stk_cnt_q < NE_W'(DICT_DEPTH)) begin
          state_d = BK_WAIT;
        end else begin
          // Chain reached its root: push it and extend the dictionary.
          first_d = n_q[7:0];
          if (stk_cnt_q < NE_W'(DICT_DEPTH)) begin
            stk_we    = 1'b1;
            stk_wdata = n_q[7:0];
            stk_cnt_d = stk_cnt_q + NE_W'(1);
          end
          if (ne_q < NE_W'(DICT_DEPTH)) begin
            dict_we = 1'b1;
            ne_d    = ne_inc;
            if (cw_q < 4'(MAX_CODE_BITS) &&
                (CMP_W+1)'(ne_inc) == ((CMP_W+1)'(1) << cw_q)) begin
              cw_d = cw_q + 4'd1;
            end
          end
          prev_d  = code_q;
          state_d = kw_q ? BK_FIX : BK_REQ;
        end
      end
      BK_WAIT: begin
        stk_we    = 1'b1;
        stk_wdata = dict_rdata[7:0];
        stk_cnt_d = stk_cnt_q + NE_W'(1);
        n_d       = dict_rdata[CW+7:8];
        state_d   = BK_WALK;
      end
      BK_FIX: begin
        stk_we    = 1'b1;
        stk_waddr = '0;
        stk_wdata = first_q;
        state_d   = BK_REQ;
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase

    // A configuration write starts a new image; the byte FIFO is kept.
    if (cfg_i.restart) begin
      state_d   = BK_IDLE;
      stk_cnt_d = '0;
      buf_d     = '0;
      bcnt_d    = '0;
      cw_d      = emin + 4'd1;
      ne_d      = NE_W'(clear_c + CMP_W'(2));
      have_d    = 1'b0;
      prev_d    = '0;
      done_d    = 1'b0;
    end
  end

  // Output register.
  always_comb begin
    ov_d   = ov_q;
    opix_d = opix_q;
    ost_d  = ost_q;
    if (emit) begin
      ov_d   = 1'b1;
      opix_d = emit_pix;
      ost_d  = emit_st;
    end else if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      stk_cnt_q <= '0;
      fcnt_q    <= '0;
      rd_q      <= '0;
      wr_q      <= '0;
      buf_q     <= '0;
      bcnt_q    <= '0;
      cw_q      <= MCS_RESET + 4'd1;
      ne_q      <= NE_W'((CMP_W'(1) << MCS_RESET) + CMP_W'(2));
      prev_q    <= '0;
      have_q    <= 1'b0;
      done_q    <= 1'b0;
      kw_q      <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      stk_cnt_q <= stk_cnt_d;
      fcnt_q    <= fcnt_d;
      rd_q      <= rd_d;
      wr_q      <= wr_d;
      buf_q     <= buf_d;
      bcnt_q    <= bcnt_d;
      cw_q      <= cw_d;
      ne_q      <= ne_d;
      prev_q    <= prev_d;
      have_q    <= have_d;
      done_q    <= done_d;
      kw_q      <= kw_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    code_q  <= code_d;
    first_q <= first_d;
    opix_q  <= opix_d;
    ost_q   <= ost_d;
  end

  assign out_valid_o   = ov_q;
  assign pixel_index_o = opix_q;
  assign status_o      = ost_q;

  // Compressed byte FIFO.
  gld_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (fifo_we),
    .waddr_i (wr_q),
    .wdata_i (item_i.data),
    .raddr_i (rd_q),
    .rdata_o (fifo_rdata)
  );

  // Pixel stack.
  gld_ram #(.WIDTH(8), .DEPTH(DICT_DEPTH)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // Dictionary: prefix code above suffix pixel.
  gld_ram #(.WIDTH(CW + 8), .DEPTH(DICT_DEPTH)) u_dict_ram (
    .clk_i   (clk_i),
    .we_i    (dict_we),
    .waddr_i (ne_q[AW-1:0]),
    .wdata_i ({prev_q, n_q[7:0]}),
    .raddr_i (n_c[AW-1:0]),
    .rdata_o (dict_rdata)
  );

endmodule
`default_nettype wire

/* rtl/gif_lzw_decoder.sv */
// Top level of the GIF LZW decoder: register port, front queue and back end.
//
//   Channel   Direction  Handshake              Payload
//   in        request    in_valid_i/in_stall_o  op_i, data_byte_i
//   out       result     out_valid_o/out_stall_i pixel_index_o, status_o
//   cfg       APB write  psel/penable/pwrite    paddr_i, pwdata_i
//
// A byte push passes through the front queue and the output register. A pixel
// request that pops a buffered pixel also passes through the request and pop
// states; one that must decode a code also loads each byte, classifies the code,
// walks each chain entry through the registered read of the dictionary RAM,
// pushes the root and patches the stack for a repeated string. Reset clears all
// control state; no clearing pass is needed. A stalled result holds the back end
// while the front queue still takes two more requests.
`default_nettype none
module gif_lzw_decoder #(
  parameter int DICT_DEPTH    = 4096,
  parameter int MAX_CODE_BITS = 12,
  parameter int FIFO_DEPTH    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  pixel_index_o,
  output logic [2:0]  status_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);
  import gld_pkg::*;

  logic       mcs_q;
  logic [3:0] mcs_val_q;
  logic       cfg_wr;
  gld_cfg_t   cfg;
  gld_item_t  item;
  logic       item_valid;
  logic       item_pop;

  // Minimum code size register.
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && (paddr_i == 3'd0);
  assign prdata_o = {28'd0, mcs_val_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcs_val_q <= MCS_RESET;
      mcs_q     <= 1'b0;
    end else begin
      mcs_q <= cfg_wr;
      if (cfg_wr) begin
        mcs_val_q <= pwdata_i[3:0];
      end
    end
  end

  // The back end sees the new value in the cycle of the write.
  assign cfg.restart       = cfg_wr;
  assign cfg.min_code_size = cfg_wr ? pwdata_i[3:0] : mcs_val_q;

  gld_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .data_byte_i  (data_byte_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  gld_back #(
    .DICT_DEPTH    (DICT_DEPTH),
    .MAX_CODE_BITS (MAX_CODE_BITS),
    .FIFO_DEPTH    (FIFO_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .item_pop_o    (item_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_index_o (pixel_index_o),
    .status_o      (status_o)
  );

`ifndef SYNTHESIS
  // Only a pixel result carries a nonzero index.
  a_pix_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_PIXEL) |-> pixel_index_o == 8'd0)
    else $error("non-pixel result with nonzero index");

  // A register write is visible on the read port in the cycle after the write.
  a_cfg_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mcs_q |-> prdata_o[3:0] == $past(pwdata_i[3:0]))
    else $error("register read does not reflect the last write");
`endif

endmodule
`default_nettype wire

/* sim/gld_checker.sv */
// Checker for the GIF LZW decoder: predicts each result and compares it.
`timescale 1ns / 1ps
module gld_checker
  import gld_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        op_i,
  input  logic [7:0]  data_byte_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  pixel_index_i,
  input  logic [2:0]  status_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          queued_bytes_o,
  output logic        image_ended_o,
  output logic        starved_o
);

  typedef struct {
    logic [7:0]  pixel;
    gld_status_e status;
  } decoded_t;

  decoded_t    expected_results[$];

  // Shadow copy of the decoder state.
  logic [7:0]  suffix_mem [4096];
  logic [11:0] prefix_mem [4096];
  logic [7:0]  pixel_stack[4096];
  logic [7:0]  byte_queue [16];
  int unsigned stack_level;
  int unsigned fifo_level;
  int unsigned fifo_head;
  int unsigned bit_acc;
  int unsigned bit_level;
  int unsigned width_now;
  int unsigned free_entry;
  logic [11:0] last_code;
  bit          seen_code;
  bit          ended;
  logic [3:0]  mcs_reg;

  assign pending_o      = expected_results.size();
  assign queued_bytes_o = fifo_level;
  assign image_ended_o  = ended;

  function automatic int unsigned root_bits();
    int unsigned m;
    m = mcs_reg;
    if (m < 2) m = 2;
    if (m > 8) m = 8;
    return m;
  endfunction

  function automatic void reset_dictionary();
    width_now  = root_bits() + 1;
    free_entry = (1 << root_bits()) + 2;
    seen_code  = 1'b0;
  endfunction

  function automatic void new_image();
    reset_dictionary();
    stack_level = 0;
    bit_acc     = 0;
    bit_level   = 0;
    last_code   = '0;
    ended       = 1'b0;
  endfunction

  function automatic void push_pixel(logic [7:0] v);
    if (stack_level < 4096) begin
      pixel_stack[stack_level] = v;
      stack_level++;
    end
  endfunction

  // Expands one data code onto the pixel stack; returns 0 for a corrupt code.
  function automatic bit expand_code(int unsigned code);
    int unsigned eoi;
    int unsigned n;
    logic [7:0]  first;
    bit          repeat_case;
    eoi = (1 << root_bits()) + 1;
    if (!seen_code) begin
      if (code > eoi) return 1'b0;
      push_pixel(code[7:0]);
      last_code = code[11:0];
      seen_code = 1'b1;
      return 1'b1;
    end
    if (code > free_entry) return 1'b0;
    repeat_case = (code == free_entry);
    if (repeat_case) push_pixel(8'd0);
    n = repeat_case ? last_code : code;
    while (n > eoi && n < 4096 && stack_level < 4096) begin
      push_pixel(suffix_mem[n]);
      n = prefix_mem[n];
    end
    first = n[7:0];
    push_pixel(first);
    // The repeated string ends in its own first pixel.
    if (repeat_case) pixel_stack[0] = first;
    if (free_entry < 4096) begin
      suffix_mem[free_entry] = first;
      prefix_mem[free_entry] = last_code;
      free_entry++;
      if (width_now < 12 && free_entry == (1 << width_now)) width_now++;
    end
    last_code = code[11:0];
    return 1'b1;
  endfunction

  // Works out the answer to one pixel request.
  function automatic decoded_t next_pixel();
    decoded_t    r;
    int unsigned code;
    int unsigned clr;
    clr     = 1 << root_bits();
    r.pixel = 8'd0;
    forever begin
      if (stack_level > 0) begin
        stack_level--;
        r.pixel  = pixel_stack[stack_level];
        r.status = ST_PIXEL;
        return r;
      end
      if (ended) begin
        r.status = ST_END;
        return r;
      end
      while (bit_level < width_now && fifo_level > 0) begin
        bit_acc    = bit_acc | ({24'd0, byte_queue[fifo_head]} << bit_level);
        fifo_head  = (fifo_head + 1) % 16;
        fifo_level--;
        bit_level += 8;
      end
      if (bit_level < width_now) begin
        r.status = ST_NEED_DATA;
        return r;
      end
      code      = bit_acc & ((1 << width_now) - 1);
      bit_acc   = (bit_acc >> width_now) & 32'h00FF_FFFF;
      bit_level = bit_level - width_now;
      if (code == clr) begin
        reset_dictionary();
      end else if (code == clr + 1) begin
        ended = 1'b1;
      end else if (!expand_code(code)) begin
        ended = 1'b1;
      end
    end
  endfunction

  // Prediction on each accepted request and comparison on each result.
  always @(posedge clk_i or negedge rst_ni) begin
    decoded_t want;
    if (!rst_ni) begin
      expected_results.delete();
      fail_count_o = 0;
      fifo_level   = 0;
      fifo_head    = 0;
      mcs_reg      = 4'd8;
      starved_o    = 1'b0;
      new_image();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == 3'd0) begin
        mcs_reg = pwdata_i[3:0];
        new_image();
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result with no request waiting: status %0d", status_i);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            fail_count_o++;
          end
          if (pixel_index_i !== want.pixel) begin
            $error("pixel_index: expected %0d, got %0d", want.pixel, pixel_index_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (op_i == OP_PUSH) begin
          want.pixel = 8'd0;
          if (fifo_level < 16) begin
            byte_queue[(fifo_head + fifo_level) % 16] = data_byte_i;
            fifo_level++;
            want.status = ST_BYTE_OK;
          end else begin
            want.status = ST_DROPPED;
          end
        end else begin
          want      = next_pixel();
          starved_o = (want.status == ST_NEED_DATA);
        end
        expected_results.push_back(want);
      end
    end
  end

endmodule

/* sim/tb_gif_lzw_decoder.sv */
// Testbench top for the GIF LZW decoder: builds code streams and drives them.
`timescale 1ns / 1ps
module tb_gif_lzw_decoder;
  import gld_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        op_i;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  pixel_index_o;
  logic [2:0]  status_o;
  logic        psel_i;
  logic        penable_i;
  logic        pwrite_i;
  logic [2:0]  paddr_i;
  logic [31:0] pwdata_i;
  logic [31:0] prdata_o;
  logic        pready_o;

  int          fail_count;
  int          pending;
  int          queued_bytes;
  logic        image_ended;
  logic        starved;

  int          sender_idle_pct;
  int          receiver_idle_pct;
  bit          hold_request;
  int          hold_cycles;
  int          quiet_cycles;

  // Code stream builder state.
  logic [7:0]  stream_bytes[$];
  int unsigned pack_acc;
  int unsigned pack_bits;
  int unsigned gen_root;
  int unsigned gen_width;
  int unsigned gen_free;
  bit          gen_started;

  gif_lzw_decoder i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .op_i, .data_byte_i,
    .out_valid_o, .out_stall_i, .pixel_index_o, .status_o,
    .psel_i, .penable_i, .pwrite_i, .paddr_i, .pwdata_i, .prdata_o, .pready_o
  );

  gld_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .op_i, .data_byte_i,
    .out_valid_i(out_valid_o), .out_stall_i, .pixel_index_i(pixel_index_o),
    .status_i(status_o), .psel_i, .penable_i, .pwrite_i, .paddr_i, .pwdata_i,
    .pready_i(pready_o), .fail_count_o(fail_count), .pending_o(pending),
    .queued_bytes_o(queued_bytes), .image_ended_o(image_ended), .starved_o(starved)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Result side: random stall, or a long hold when one is asked for.
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_cycles  = 300;
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < receiver_idle_pct);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel_i) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic int unsigned clamp_mcs(logic [3:0] v);
    if (v < 2) return 2;
    if (v > 8) return 8;
    return v;
  endfunction

  function automatic void start_stream(int unsigned root);
    gen_root    = root;
    gen_width   = root + 1;
    gen_free    = (1 << root) + 2;
    gen_started = 1'b0;
  endfunction

  // Packs one code LSB first and tracks the dictionary as a decoder would.
  function automatic void emit_code(int unsigned c);
    int unsigned clr;
    clr       = 1 << gen_root;
    pack_acc  = pack_acc | (c << pack_bits);
    pack_bits = pack_bits + gen_width;
    while (pack_bits >= 8) begin
      stream_bytes.push_back(pack_acc[7:0]);
      pack_acc  = pack_acc >> 8;
      pack_bits = pack_bits - 8;
    end
    if (c == clr) begin
      start_stream(gen_root);
    end else if (!gen_started) begin
      gen_started = 1'b1;
    end else if (gen_free < 4096) begin
      gen_free++;
      if (gen_width < 12 && gen_free == (1 << gen_width)) gen_width++;
    end
  endfunction

  function automatic void flush_stream();
    if (pack_bits > 0) stream_bytes.push_back(pack_acc[7:0]);
    pack_acc  = 0;
    pack_bits = 0;
  endfunction

  // Mostly dictionary references, some roots, repeats and the odd clear.
  function automatic int unsigned pick_code();
    int unsigned clr;
    int unsigned r;
    clr = 1 << gen_root;
    if (!gen_started) return $urandom_range(clr - 1, 0);
    r = $urandom_range(99);
    if (r < 2) return clr;
    if (r < 55 && gen_free > clr + 2) return $urandom_range(gen_free, clr + 2);
    if (r < 62) return gen_free;
    return $urandom_range(clr - 1, 0);
  endfunction

  // Offers one request and waits until it is taken.
  task automatic send(input logic op, input logic [7:0] d);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid_i  <= 1'b1;
    op_i        <= op;
    data_byte_i <= d;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Stops offering requests and waits until every result is back.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_mcs(input logic [3:0] v);
    wait_idle();
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= 3'd0;
    pwdata_i  <= {8'($urandom_range(255, 0)), 20'd0, v};
    @(negedge clk_i);
    penable_i <= 1'b1;
    @(negedge clk_i);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
  endtask

  // Feeds the rest of the stream, without overflowing until the image has ended, then pulls pixels out.
  task automatic finish_image(input bit noisy);
    logic [7:0] b;
    while (stream_bytes.size() > 0) begin
      if ((queued_bytes < 16 || image_ended) && $urandom_range(99) < 60) begin
        b = stream_bytes.pop_front();
        if (noisy && $urandom_range(99) < 3) b = 8'($urandom_range(255));
        send(OP_PUSH, b);
      end else begin
        send(OP_PIXEL, 8'($urandom_range(255)));
      end
    end
    send(OP_PIXEL, 8'($urandom_range(255)));
    while (!image_ended && !starved) send(OP_PIXEL, 8'($urandom_range(255)));
  endtask

  // One image at the given register value with random traffic.
  task automatic run_image(input logic [3:0] mcs, input int n_items, input bit noisy);
    logic [7:0] b;
    write_mcs(mcs);
    start_stream(clamp_mcs(mcs));
    emit_code(1 << gen_root);
    for (int k = 0; k < n_items; k++) begin
      while (stream_bytes.size() < 3) emit_code(pick_code());
      if (queued_bytes < 16 && $urandom_range(99) < 45) begin
        b = stream_bytes.pop_front();
        if (noisy && $urandom_range(99) < 3) b = 8'($urandom_range(255));
        send(OP_PUSH, b);
      end else begin
        send(OP_PIXEL, 8'($urandom_range(255)));
      end
    end
    emit_code((1 << gen_root) + 1);
    flush_stream();
    finish_image(noisy);
  endtask

  initial begin
    logic [3:0] image_mcs[9];
    image_mcs = '{4'd2, 4'd8, 4'd0, 4'd5, 4'd15, 4'd3, 4'd1, 4'd7, 4'd9};
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    op_i              = OP_PUSH;
    data_byte_i       = 8'd0;
    out_stall_i       = 1'b0;
    psel_i            = 1'b0;
    penable_i         = 1'b0;
    pwrite_i          = 1'b0;
    paddr_i           = 3'd0;
    pwdata_i          = 32'd0;
    hold_request      = 1'b0;
    hold_cycles       = 0;
    quiet_cycles      = 0;
    pack_acc          = 0;
    pack_bits         = 0;
    sender_idle_pct   = 28;
    receiver_idle_pct = 85;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset value of the register, need-data, dictionary references, extreme roots.
    start_stream(8);
    send(OP_PIXEL, 8'd0);
    emit_code(256);
    emit_code(0);
    emit_code(255);
    emit_code(258);
    emit_code(259);
    emit_code(257);
    flush_stream();
    finish_image(1'b0);
    send(OP_PIXEL, 8'hFF);
    send(OP_PIXEL, 8'h00);

    // A code past the next free entry ends the image.
    write_mcs(4'd3);
    start_stream(3);
    emit_code(8);
    emit_code(1);
    emit_code(13);
    flush_stream();
    finish_image(1'b0);

    // Random images over the idle profiles.
    for (int s = 0; s < 9; s++) begin
      if (s == 3) begin
        sender_idle_pct   = 85;
        receiver_idle_pct = 28;
      end
      if (s == 6) begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        hold_request      = 1'b1;
      end
      run_image(image_mcs[s], 165, s == 4);
    end

    // Bytes after the end of an image, more pushes than the queue holds.
    for (int k = 0; k < 20; k++) send(OP_PUSH, k[0] ? 8'hFF : 8'h00);
    send(OP_PIXEL, 8'd0);
    send(OP_PIXEL, 8'd0);
    in_valid_i <= 1'b0;

    wait_idle();
    repeat (20) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/gld_pkg.sv
rtl/gld_ram.sv
rtl/gld_front.sv
rtl/gld_back.sv
rtl/gif_lzw_decoder.sv
sim/gld_checker.sv
sim/tb_gif_lzw_decoder.sv
